@@ hdl/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

@@ hdl/rme_pkg.sv @@
// Types, constants and the arctangent table for the matrix-to-Euler block.
`default_nettype none
package rme_pkg;
    localparam int SQ_STEPS          = 16;
    localparam int XY_W              = 42;
    localparam int Z_W               = 34;
    localparam int IN_SCALE          = 20;
    localparam int OUT_SHIFT         = 17;
    localparam int ANG_LIMIT         = 25736;
    localparam int THR_W             = 15;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam logic [THR_W-1:0] THR_RESET = 15'd1;
    localparam logic signed [Z_W-1:0] HALF_PI = 34'sd1686629714;

    typedef struct packed {
        logic [31:0] n;
        logic [19:0] rem;
        logic [15:0] root;
    } sq_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } vec_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m10;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic signed [15:0] m12;
        logic signed [15:0] m11;
    } mat_t;

    // atan(2^-i) in radians * 2^30, rounded
    function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
        logic signed [Z_W-1:0] a;
        case (idx)
            0:  a = 34'sd843314857;
            1:  a = 34'sd497837829;
            2:  a = 34'sd263043837;
            3:  a = 34'sd133525159;
            4:  a = 34'sd67021687;
            5:  a = 34'sd33543516;
            6:  a = 34'sd16775851;
            7:  a = 34'sd8388437;
            8:  a = 34'sd4194283;
            9:  a = 34'sd2097149;
            10: a = 34'sd1048576;
            11: a = 34'sd524288;
            12: a = 34'sd262144;
            13: a = 34'sd131072;
            14: a = 34'sd65536;
            15: a = 34'sd32768;
            16: a = 34'sd16384;
            17: a = 34'sd8192;
            18: a = 34'sd4096;
            19: a = 34'sd2048;
            20: a = 34'sd1024;
            21: a = 34'sd512;
            22: a = 34'sd256;
            23: a = 34'sd128;
            24: a = 34'sd64;
            25: a = 34'sd32;
            26: a = 34'sd16;
            27: a = 34'sd8;
            28: a = 34'sd4;
            29: a = 34'sd2;
            30: a = 34'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction
endpackage
`default_nettype wire

@@ hdl/rme_sqrt_cell.sv @@
// One digit step of the pipelined integer square root.
`default_nettype none
module rme_sqrt_cell
    import rme_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire sq_t  d,
    output sq_t       q
);
    sq_t         q_reg;
    sq_t         q_next;
    logic [19:0] rem_sh;
    logic [19:0] trial;

    // bring down two bits, try subtracting 4r+1
    always_comb
    begin
        rem_sh = {d.rem[17:0], d.n[31:30]};
        trial  = {2'b00, d.root, 2'b01};
        q_next.n = {d.n[29:0], 2'b00};
        if (rem_sh >= trial)
        begin
            q_next.rem  = rem_sh - trial;
            q_next.root = {d.root[14:0], 1'b1};
        end
        else
        begin
            q_next.rem  = rem_sh;
            q_next.root = {d.root[14:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;
endmodule
`default_nettype wire

@@ hdl/rme_cordic_cell.sv @@
// One vectoring micro-rotation of the arctangent chain.
`default_nettype none
module rme_cordic_cell
    import rme_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic clk,
    input  wire logic en,
    input  wire vec_t d,
    output vec_t      q
);
    localparam logic signed [Z_W-1:0] ANG = atan_q30(IDX);

    vec_t                   q_reg;
    vec_t                   q_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    // drive y toward zero, accumulate the angle
    always_comb
    begin
        xs = d.x >>> IDX;
        ys = d.y >>> IDX;
        q_next.zero = d.zero;
        if (!d.y[XY_W-1])
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + ANG;
        end
        else
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;
endmodule
`default_nettype wire

@@ hdl/rotation_matrix_to_euler.sv @@
// Rotation matrix to ZYX Euler angles: top level.
// Usage:
//  - Input channel in_valid/in_ready carries one word: seven matrix entries
//    m00..m11, signed Q1.14. Output channel out_valid/out_ready carries roll,
//    pitch, yaw (signed Q2.13 rad) and the gimbal-lock flag singular.
//  - cfg_we/cfg_wdata write singular_threshold; write it only
//    while the pipeline is empty.
//  - Pipeline stages in order: the squaring register, 16 root digit cells,
//    the pre-rotation register, CORDIC_STAGES rotation cells and the
//    output register.
//  - Throughput is one word per cycle unless the output stalls; all stages advance together.
//  - When the receiver stalls with a word held in the output register, the
//    whole pipeline freezes and in_ready drops in the same cycle; words in
//    flight are kept, none are lost.
//  - Reset empties the pipeline (all valid bits clear) and sets the
//    threshold to 1, so only a zero magnitude counts as singular.
`default_nettype none
`include "assert_macros.svh"
module rotation_matrix_to_euler
    import rme_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] m00,
    input  wire logic signed [15:0] m10,
    input  wire logic signed [15:0] m20,
    input  wire logic signed [15:0] m21,
    input  wire logic signed [15:0] m22,
    input  wire logic signed [15:0] m12,
    input  wire logic signed [15:0] m11,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      roll,
    output logic signed [15:0]      pitch,
    output logic signed [15:0]      yaw,
    output logic                    singular,
    input  wire logic               cfg_we,
    input  wire logic [THR_W-1:0]   cfg_wdata
);
    localparam int NSTG = SQ_STEPS + CORDIC_STAGES + 3;

    logic             adv;
    logic [NSTG-1:0]  vld_reg;
    logic [THR_W-1:0] thr_reg;

    mat_t        mat0_reg;
    logic [31:0] p0_reg;
    logic [31:0] p1_reg;
    sq_t         sq_in;
    sq_t         sq_q   [SQ_STEPS];
    mat_t        mat_reg[SQ_STEPS];

    vec_t vr  [CORDIC_STAGES+1];
    vec_t vp  [CORDIC_STAGES+1];
    vec_t vy  [CORDIC_STAGES+1];
    logic sing_reg[CORDIC_STAGES+1];

    logic        sing_pre;
    logic [15:0] sy;
    mat_t        mq;

    logic signed [15:0] roll_reg;
    logic signed [15:0] pitch_reg;
    logic signed [15:0] yaw_reg;
    logic               sing_out_reg;

    // pre-rotation into the right half plane, inputs scaled by 2^20
    function automatic vec_t prep(input logic signed [16:0] y, input logic signed [16:0] x);
        vec_t                   v;
        logic signed [XY_W-1:0] xw;
        logic signed [XY_W-1:0] yw;
        xw = XY_W'(x) <<< IN_SCALE;
        yw = XY_W'(y) <<< IN_SCALE;
        v.zero = (x == 17'sd0) && (y == 17'sd0);
        if (x[16])
        begin
            if (!y[16])
            begin
                v.x = yw;
                v.y = -xw;
                v.z = HALF_PI;
            end
            else
            begin
                v.x = -yw;
                v.y = xw;
                v.z = -HALF_PI;
            end
        end
        else
        begin
            v.x = xw;
            v.y = yw;
            v.z = '0;
        end
        return v;
    endfunction

    // round to Q2.13 and clamp to +-pi
    function automatic logic signed [15:0] fin(input vec_t v);
        logic signed [Z_W-1:0]           zz;
        logic signed [Z_W-OUT_SHIFT-1:0] zr;
        logic signed [15:0]              r;
        zz = v.z + (Z_W'(1) <<< (OUT_SHIFT - 1));
        zr = (Z_W-OUT_SHIFT)'(zz >>> OUT_SHIFT);
        if (v.zero)
            r = '0;
        else if (zr > (Z_W-OUT_SHIFT)'(ANG_LIMIT))
            r = 16'(ANG_LIMIT);
        else if (zr < -(Z_W-OUT_SHIFT)'(ANG_LIMIT))
            r = -16'(ANG_LIMIT);
        else
            r = 16'(zr);
        return r;
    endfunction

    // whole pipeline moves unless the output word is stuck
    assign adv      = !vld_reg[NSTG-1] || out_ready;
    assign in_ready = adv;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    // squaring stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mat0_reg <= '{m00, m10, m20, m21, m22, m12, m11};
            p0_reg   <= 32'(m00 * m00);
            p1_reg   <= 32'(m10 * m10);
        end
    end

    assign sq_in.n    = p0_reg + p1_reg;
    assign sq_in.rem  = '0;
    assign sq_in.root = '0;

    // square root digit cells, matrix entries ride alongside
    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++)
        begin : g_sq
            if (k == 0)
            begin : g_first
                rme_sqrt_cell u_cell (.clk(clk), .en(adv), .d(sq_in), .q(sq_q[k]));
                always_ff @(posedge clk)
                begin
                    if (adv)
                        mat_reg[k] <= mat0_reg;
                end
            end
            else
            begin : g_rest
                rme_sqrt_cell u_cell (.clk(clk), .en(adv), .d(sq_q[k-1]), .q(sq_q[k]));
                always_ff @(posedge clk)
                begin
                    if (adv)
                        mat_reg[k] <= mat_reg[k-1];
                end
            end
        end
    endgenerate

    // singular test and pre-rotation stage
    assign sy       = sq_q[SQ_STEPS-1].root;
    assign mq       = mat_reg[SQ_STEPS-1];
    assign sing_pre = {1'b0, sy} < {2'b00, thr_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sing_reg[0] <= sing_pre;
            vp[0]       <= prep(-17'(mq.m20), {1'b0, sy});
            vy[0]       <= prep(17'(mq.m10), 17'(mq.m00));
            if (sing_pre)
                vr[0] <= prep(-17'(mq.m12), 17'(mq.m11));
            else
                vr[0] <= prep(17'(mq.m21), 17'(mq.m22));
        end
    end

    // three rotation chains
    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_cor
            rme_cordic_cell #(.IDX(i)) u_roll
                (.clk(clk), .en(adv), .d(vr[i]), .q(vr[i+1]));
            rme_cordic_cell #(.IDX(i)) u_pitch
                (.clk(clk), .en(adv), .d(vp[i]), .q(vp[i+1]));
            rme_cordic_cell #(.IDX(i)) u_yaw
                (.clk(clk), .en(adv), .d(vy[i]), .q(vy[i+1]));
            always_ff @(posedge clk)
            begin
                if (adv)
                    sing_reg[i+1] <= sing_reg[i];
            end
        end
    endgenerate

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_reg     <= fin(vr[CORDIC_STAGES]);
            pitch_reg    <= fin(vp[CORDIC_STAGES]);
            yaw_reg      <= sing_reg[CORDIC_STAGES] ? 16'sd0 : fin(vy[CORDIC_STAGES]);
            sing_out_reg <= sing_reg[CORDIC_STAGES];
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign roll      = roll_reg;
    assign pitch     = pitch_reg;
    assign yaw       = yaw_reg;
    assign singular  = sing_out_reg;

    `ASSERT_IMP(a_yaw_zero, clk, rst_n, out_valid && singular, yaw == 16'sd0)
    `ASSERT_IMP(a_roll_rng, clk, rst_n, out_valid, (roll <= 16'sd25736) && (roll >= -16'sd25736))
    `ASSERT_IMP(a_rdy_empty, clk, rst_n, !out_valid, in_ready)
    `ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pitch))
endmodule
`default_nettype wire

@@ tb/rotation_matrix_to_euler_checker.sv @@
// Checker for the matrix-to-Euler block: predicts angles and compares output words.
`timescale 1ns / 100ps
module rotation_matrix_to_euler_checker
    import rme_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic signed [15:0] m00,
    input  wire logic signed [15:0] m10,
    input  wire logic signed [15:0] m20,
    input  wire logic signed [15:0] m21,
    input  wire logic signed [15:0] m22,
    input  wire logic signed [15:0] m12,
    input  wire logic signed [15:0] m11,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [15:0] roll,
    input  wire logic signed [15:0] pitch,
    input  wire logic signed [15:0] yaw,
    input  wire logic               singular,
    input  wire logic               cfg_we,
    input  wire logic [THR_W-1:0]   cfg_wdata,
    output int                      fail_count,
    output int                      pending,
    output int                      words_out,
    output int                      singular_seen
);
    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               singular;
    } angles_t;

    angles_t angles_q[$];
    logic [THR_W-1:0] threshold;

    // Arctangent per the vectoring CORDIC, Q2.13 result
    function automatic logic signed [15:0] vector_angle(longint y_in, longint x_in);
        longint x, y, z, t, xs, ys;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0)
            return '0;
        x = x * (longint'(1) << 20);
        y = y * (longint'(1) << 20);
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 2 * 843314857;
            end
            else begin
                x = -y; y = t; z = -2 * 843314857;
            end
        end
        for (int i = 0; i < CORDIC_STAGES_DEF && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(atan_q30(i));
            end
            else begin
                x -= ys; y += xs; z -= longint'(atan_q30(i));
            end
        end
        z = (z + (longint'(1) << 16)) >>> 17;
        if (z > 25736) z = 25736;
        if (z < -25736) z = -25736;
        return z[15:0];
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r, b;
        r = 0;
        b = longint'(1) << 40;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b); r = (r >> 1) + b;
            end
            else r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic angles_t predict_angles();
        angles_t a;
        longint sy;
        sy = int_sqrt(longint'(m00) * m00 + longint'(m10) * m10);
        a.singular = sy < longint'(threshold);
        a.pitch = vector_angle(-longint'(m20), sy);
        if (!a.singular) begin
            a.roll = vector_angle(m21, m22);
            a.yaw  = vector_angle(m10, m00);
        end
        else begin
            a.roll = vector_angle(-longint'(m12), m11);
            a.yaw  = '0;
        end
        return a;
    endfunction

    // Track config, predict on input word, compare on output word
    always @(posedge clk or negedge rst_n) begin
        angles_t exp_a;
        if (!rst_n) begin
            threshold     <= THR_RESET;
            fail_count    <= 0;
            pending       <= 0;
            words_out     <= 0;
            singular_seen <= 0;
            angles_q.delete();
        end
        else begin
            if (cfg_we)
                threshold <= cfg_wdata;
            if (in_valid && in_ready)
                angles_q.push_back(predict_angles());
            if (out_valid && out_ready) begin
                words_out <= words_out + 1;
                if (singular) singular_seen <= singular_seen + 1;
                if (angles_q.size() == 0) begin
                    $display("%0t: unexpected word roll=%0d pitch=%0d yaw=%0d sing=%0b",
                             $time, roll, pitch, yaw, singular);
                    fail_count <= fail_count + 1;
                end
                else begin
                    exp_a = angles_q.pop_front();
                    if (exp_a !== {roll, pitch, yaw, singular}) begin
                        $display("%0t: mismatch expected r=%0d p=%0d y=%0d s=%0b",
                                 $time, exp_a.roll, exp_a.pitch, exp_a.yaw,
                                 exp_a.singular);
                        $display("%0t:          actual   r=%0d p=%0d y=%0d s=%0b",
                                 $time, roll, pitch, yaw, singular);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= angles_q.size();
        end
    end
endmodule

@@ tb/rotation_matrix_to_euler_tb.sv @@
// Testbench top for the matrix-to-Euler block: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module rotation_matrix_to_euler_tb;
    import rme_pkg::*;

    localparam int LATENCY = CORDIC_STAGES_DEF + 19;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [THR_W-1:0] cfg_wdata = '0;
    logic signed [15:0] m00 = '0, m10 = '0, m20 = '0, m21 = '0;
    logic signed [15:0] m22 = '0, m12 = '0, m11 = '0;
    logic in_ready, out_valid, singular;
    logic signed [15:0] roll, pitch, yaw;
    int fail_count, pending, words_out, singular_seen;
    int cycles = 0;
    int words_in = 0;
    int stall_mode = 1;

    always #4 clk = ~clk;

    rotation_matrix_to_euler u_top (.*);

    rotation_matrix_to_euler_checker u_chk (.*);

    // Run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Receiver stalls; mode 0 keeps ready high
    always @(negedge clk) begin
        if (stall_mode == 0)
            out_ready <= 1'b1;
        else if (stall_mode == 2)
            out_ready <= ($urandom_range(0, 9) < 3);
        else
            out_ready <= ($urandom_range(0, 9) < 7);
    end

    function automatic logic signed [15:0] rand_entry();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return 16'(16'sd16384 * ($urandom_range(0, 1) ? 1 : -1));
        if (r == 2) return 16'($urandom_range(0, 8)) - 16'sd4;
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic send_matrix(input logic signed [15:0] a0, a1, a2, a3, a4, a5, a6);
        int g;
        m00 <= a0; m10 <= a1; m20 <= a2; m21 <= a3;
        m22 <= a4; m12 <= a5; m11 <= a6;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        words_in++;
        @(negedge clk);
        g = gap_len();
        if (stall_mode != 0 && g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic drain_and_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_matrix();
        int r;
        logic signed [15:0] c, s;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            // near gimbal lock: tiny first column, m20 at +-1
            c = 16'(int'($urandom_range(0, 600)) - 300);
            s = 16'(int'($urandom_range(0, 600)) - 300);
            send_matrix(c, s, $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384,
                        rand_entry(), rand_entry(), rand_entry(), rand_entry());
        end
        else
            send_matrix(rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                        rand_entry(), rand_entry(), rand_entry());
    endtask

    initial begin
        logic [THR_W-1:0] thr_set [4];
        thr_set = '{15'd0, 15'd200, 15'd16384, 15'h7FFF};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, zero vector, negative x, singular at reset threshold
        stall_mode = 0;
        send_matrix(16'sd16384, 0, 0, 0, 16'sd16384, 0, 16'sd16384);
        send_matrix(0, 0, 16'sd16384, 16'sd16384, 0, 16'sd16384, 0);
        send_matrix(0, 0, -16'sd16384, 0, 0, 0, 0);
        send_matrix(0, 0, 0, 0, 0, 0, 0);
        send_matrix(-16'sd16384, 0, 0, 0, -16'sd16384, 0, -16'sd16384);
        send_matrix(-16'sd16384, -16'sd1, 0, -16'sd1, -16'sd16384, 16'sd1, -16'sd1);
        send_matrix(-16'sd16384, 16'sd1, 0, 16'sd1, -16'sd16384, 0, 0);
        send_matrix(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                    16'sh7FFF, 16'sh7FFF);
        send_matrix(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                    16'sh8000, 16'sh8000);
        send_matrix(16'sh8000, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, 16'sh8000);
        send_matrix(16'sd11585, 16'sd11585, 0, 16'sd11585, 16'sd11585, 0, 16'sd1);
        send_matrix(0, -16'sd16384, 0, -16'sd16384, 0, 0, 16'sd5);
        send_matrix(16'sd1, 0, 16'sd16384, 0, 0, -16'sd7, 16'sd3);
        drain_and_idle();

        // Random phases over several thresholds, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 4) set_threshold(thr_set[ph]);
            else set_threshold(15'($urandom_range(0, 16384)));
            stall_mode = ph % 3;
            repeat (300) random_matrix();
            drain_and_idle();
        end
        set_threshold(THR_RESET);
        repeat (20) random_matrix();
        drain_and_idle();

        $display("Sent %0d matrices, checked %0d angle words, %0d of them gimbal-locked.",
                 words_in, words_out, singular_seen);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hdl
hdl/rme_pkg.sv
hdl/rme_sqrt_cell.sv
hdl/rme_cordic_cell.sv
hdl/rotation_matrix_to_euler.sv
tb/rotation_matrix_to_euler_checker.sv
tb/rotation_matrix_to_euler_tb.sv
